/* hdl/adlf_pkg.sv */
package adlf_pkg;

   localparam int unsigned LINE_MAX_DEFAULT = 8192;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned FIELDS_W    = 12;
   localparam int unsigned CHARS_W     = 13;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned INDEX_W     = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIELDS_TO_SKIP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_TO_SKIP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE    = 2'd2;

   localparam logic [MODE_W-1:0] MODE_ALL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNIQUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DUP    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd3;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] first_line_index;
      logic [COUNT_W-1:0] group_count;
      logic               too_long;
   } rsp_type;

endpackage

/* hdl/adjacent_duplicate_line_filter_unit.sv */
// Adjacent duplicate line filter.
// The req channel carries one text byte per beat (newline ends a line) or an
// end-of-input marker that flushes the open group and restarts line numbering.
// The rsp channel carries one beat per reported group: index of its first line
// and its line count (saturating), or a single too_long beat for a line of
// LINE_MAX-2 or more bytes, after which the block drops all input until reset.
// The csr port writes fields_to_skip, chars_to_skip and filter_mode; write it
// only while no beat is in flight.
// Throughput: one req beat per cycle while rsp does not stall. Each byte needs
// one read of the group line's key byte and one write of the new line's key
// byte; the key store is a two-bank RAM with one read and one write port, and
// the compare with the registered read data is folded in on the following byte.
// A result is written into the rsp register when the req beat that closes the
// group leaves the input register.
// When rsp stalls, the result holds and one more req beat is taken into the
// input register; req_stall then rises until the result leaves.
// Reset clears all control state but not the data registers or key store
// contents; only key store entries written by the current group line are read.
module adjacent_duplicate_line_filter_unit
   import adlf_pkg::*;
#(
   parameter int unsigned LINE_MAX = LINE_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned LW = $clog2(LINE_MAX + 1);
   localparam int unsigned AW = $clog2(LINE_MAX);

   typedef enum logic [1:0] {
      PH_BLANK = 2'd0,
      PH_FIELD = 2'd1,
      PH_CHARS = 2'd2,
      PH_KEY   = 2'd3
   } phase_type;

   logic [FIELDS_W-1:0] fields_cfg_ff, fields_cfg_in;
   logic [CHARS_W-1:0]  chars_cfg_ff, chars_cfg_in;
   logic [MODE_W-1:0]   mode_cfg_ff, mode_cfg_in;

   logic                in_vld_ff, in_vld_in;
   req_type             in_data_ff, in_data_in;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [LW-1:0]       klen_ff [2];
   logic [LW-1:0]       klen_in [2];
   logic                bank_ff, bank_in;
   logic [LW-1:0]       kpos_ff, kpos_in;
   logic [LW-1:0]       llen_ff, llen_in;
   logic [FIELDS_W-1:0] fskip_ff, fskip_in;
   logic [CHARS_W-1:0]  cskip_ff, cskip_in;
   phase_type           phase_ff, phase_in;
   logic                mism_ff, mism_in;
   logic                cend_ff, cend_in;
   logic [COUNT_W-1:0]  glines_ff, glines_in;
   logic [INDEX_W-1:0]  gstart_ff, gstart_in;
   logic [INDEX_W-1:0]  lnum_ff, lnum_in;
   logic                gopen_ff, gopen_in;
   logic                halt_ff, halt_in;
   logic                pend_ff, pend_in;
   logic [7:0]          cmp_byte_ff, cmp_byte_in;

   logic                out_free, fire, accept;
   logic                mism_eff, blank, done, take, keep, match;
   phase_type           ph_v;
   logic [FIELDS_W-1:0] fs_v;
   logic [CHARS_W-1:0]  cs_v;
   logic                mem_re, mem_we;
   logic [AW:0]         mem_raddr, mem_waddr;
   logic [7:0]          mem_rdata;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   assign mism_eff = mism_ff || (pend_ff && (mem_rdata != cmp_byte_ff));

   always_comb begin
      fields_cfg_in = fields_cfg_ff;
      chars_cfg_in  = chars_cfg_ff;
      mode_cfg_in   = mode_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIELDS_TO_SKIP: fields_cfg_in = csr_wdata[FIELDS_W-1:0];
            CSR_CHARS_TO_SKIP:  chars_cfg_in  = csr_wdata[CHARS_W-1:0];
            CSR_FILTER_MODE:    mode_cfg_in   = csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (mode_cfg_ff)
         MODE_UNIQUE: keep = (glines_ff == COUNT_W'(1));
         MODE_DUP:    keep = (glines_ff > COUNT_W'(1));
         default:     keep = 1'b1;
      endcase
   end

   always_comb begin
      blank = (in_data_ff.text_byte == CHAR_SPACE) || (in_data_ff.text_byte == CHAR_TAB);
      ph_v  = phase_ff;
      fs_v  = fskip_ff;
      cs_v  = cskip_ff;
      done  = 1'b0;
      take  = 1'b0;
      if (ph_v == PH_FIELD) begin
         if (blank) begin
            fs_v = fs_v + FIELDS_W'(1);
            ph_v = PH_BLANK;
         end else begin
            done = 1'b1;
         end
      end
      if (!done && ph_v == PH_BLANK) begin
         if (fs_v >= fields_cfg_ff) begin
            ph_v = PH_CHARS;
         end else if (blank) begin
            done = 1'b1;
         end else begin
            ph_v = PH_FIELD;
            done = 1'b1;
         end
      end
      if (!done && ph_v == PH_CHARS) begin
         if (cs_v >= chars_cfg_ff) begin
            ph_v = PH_KEY;
         end else begin
            cs_v = cs_v + CHARS_W'(1);
            done = 1'b1;
         end
      end
      if (!done && ph_v == PH_KEY) begin
         take = 1'b1;
      end
   end

   assign match = gopen_ff && !mism_eff &&
                  ((kpos_ff == klen_ff[bank_ff]) ||
                   (mode_cfg_ff == MODE_PREFIX && kpos_ff > klen_ff[bank_ff]));

   assign mem_raddr = {bank_ff, kpos_ff[AW-1:0]};
   assign mem_waddr = {~bank_ff, kpos_ff[AW-1:0]};

   always_comb begin
      in_vld_in   = accept ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
      in_data_in  = accept ? req_data : in_data_ff;
      rsp_vld_in  = out_free ? 1'b0 : rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      klen_in     = klen_ff;
      bank_in     = bank_ff;
      kpos_in     = kpos_ff;
      llen_in     = llen_ff;
      fskip_in    = fskip_ff;
      cskip_in    = cskip_ff;
      phase_in    = phase_ff;
      mism_in     = mism_ff;
      cend_in     = cend_ff;
      glines_in   = glines_ff;
      gstart_in   = gstart_ff;
      lnum_in     = lnum_ff;
      gopen_in    = gopen_ff;
      halt_in     = halt_ff;
      pend_in     = pend_ff;
      cmp_byte_in = cmp_byte_ff;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      if (fire && !halt_ff) begin
         pend_in = 1'b0;
         mism_in = mism_eff;
         if (in_data_ff.end_of_input) begin
            if (gopen_ff && keep) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = '{first_line_index: gstart_ff, group_count: glines_ff,
                               too_long: 1'b0};
            end
            gopen_in = 1'b0;
            lnum_in  = '0;
            kpos_in  = '0;
            llen_in  = '0;
            fskip_in = '0;
            cskip_in = '0;
            phase_in = PH_BLANK;
            mism_in  = 1'b0;
            cend_in  = 1'b0;
         end else if (in_data_ff.text_byte == CHAR_NL) begin
            if (llen_ff >= LW'(LINE_MAX - 2)) begin
               halt_in     = 1'b1;
               rsp_vld_in  = 1'b1;
               rsp_data_in = '{first_line_index: lnum_ff, group_count: '0, too_long: 1'b1};
            end else begin
               klen_in[~bank_ff] = kpos_ff;
               if (match) begin
                  if (glines_ff != COUNT_MAX) begin
                     glines_in = glines_ff + COUNT_W'(1);
                  end
               end else begin
                  if (gopen_ff && keep) begin
                     rsp_vld_in  = 1'b1;
                     rsp_data_in = '{first_line_index: gstart_ff, group_count: glines_ff,
                                     too_long: 1'b0};
                  end
                  bank_in   = ~bank_ff;
                  gstart_in = lnum_ff;
                  glines_in = COUNT_W'(1);
                  gopen_in  = 1'b1;
               end
               lnum_in  = lnum_ff + INDEX_W'(1);
               kpos_in  = '0;
               llen_in  = '0;
               fskip_in = '0;
               cskip_in = '0;
               phase_in = PH_BLANK;
               mism_in  = 1'b0;
               cend_in  = 1'b0;
            end
         end else begin
            if (llen_ff < LW'(LINE_MAX)) begin
               llen_in = llen_ff + LW'(1);
            end
            if (!cend_ff) begin
               if (in_data_ff.text_byte == CHAR_NUL) begin
                  cend_in = 1'b1;
               end else begin
                  phase_in = ph_v;
                  fskip_in = fs_v;
                  cskip_in = cs_v;
                  if (take && kpos_ff < LW'(LINE_MAX)) begin
                     mem_we      = 1'b1;
                     mem_re      = 1'b1;
                     pend_in     = gopen_ff && (kpos_ff < klen_ff[bank_ff]);
                     cmp_byte_in = in_data_ff.text_byte;
                     kpos_in     = kpos_ff + LW'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_cfg_ff <= '0;
         chars_cfg_ff  <= '0;
         mode_cfg_ff   <= MODE_ALL;
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         klen_ff[0]    <= '0;
         klen_ff[1]    <= '0;
         bank_ff       <= 1'b0;
         kpos_ff       <= '0;
         llen_ff       <= '0;
         fskip_ff      <= '0;
         cskip_ff      <= '0;
         phase_ff      <= PH_BLANK;
         mism_ff       <= 1'b0;
         cend_ff       <= 1'b0;
         glines_ff     <= '0;
         gstart_ff     <= '0;
         lnum_ff       <= '0;
         gopen_ff      <= 1'b0;
         halt_ff       <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         fields_cfg_ff <= fields_cfg_in;
         chars_cfg_ff  <= chars_cfg_in;
         mode_cfg_ff   <= mode_cfg_in;
         in_vld_ff     <= in_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         klen_ff       <= klen_in;
         bank_ff       <= bank_in;
         kpos_ff       <= kpos_in;
         llen_ff       <= llen_in;
         fskip_ff      <= fskip_in;
         cskip_ff      <= cskip_in;
         phase_ff      <= phase_in;
         mism_ff       <= mism_in;
         cend_ff       <= cend_in;
         glines_ff     <= glines_in;
         gstart_ff     <= gstart_in;
         lnum_ff       <= lnum_in;
         gopen_ff      <= gopen_in;
         halt_ff       <= halt_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
      cmp_byte_ff <= cmp_byte_in;
   end

   adlf_key_ram #(
      .ADDR_W (AW + 1)
   ) u_key_ram (
      .clock   (clock),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (in_data_ff.text_byte)
   );

endmodule

/* hdl/adlf_key_ram.sv */
module adlf_key_ram
   import adlf_pkg::*;
#(
   parameter int unsigned ADDR_W = 14
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] key_mem_ff [2**ADDR_W];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
